// ===== rtl/dielectric_fresnel_reflectance_top_macros.svh =====
// assertion helpers shared by the rtl
`ifndef DIELECTRIC_FRESNEL_REFLECTANCE_TOP_MACROS_SVH
`define DIELECTRIC_FRESNEL_REFLECTANCE_TOP_MACROS_SVH

// clocked check, masked while reset is high
`define DFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define DFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dfr_pkg;
   localparam int FRAC_BITS_DEF = 15;
   // internal fixed point precision
   localparam int WB = 30;
   localparam int INDEX_W = 15;
   localparam logic [INDEX_W-1:0] INDEX_ONE = 15'd8192;

   // fields that ride along the iterative units
   typedef struct packed {
      logic [INDEX_W-1:0] n1;
      logic [INDEX_W-1:0] n2;
      logic [WB:0]        c;
      logic               tir;
   } carry_type;
endpackage
`default_nettype wire

// ===== rtl/dielectric_fresnel_reflectance_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Unpolarized dielectric Fresnel reflectance, fully pipelined: one transfer can enter on
// req_ every cycle and its result leaves on rsp_ after 100 pipeline stages plus the output
// register. Most of that depth comes from the four bit-serial units laid out as stages:
// the (n1/n2)^2 scaling divide (30 stages), the square root of cos_t^2 (31 stages) and the
// two amplitude ratio divides that run side by side (30 stages). A stall on rsp_ freezes
// the whole pipe and drops req_tready; nothing is lost or repeated. Cosine above 1.0 is
// clamped, indices below 1.0 are raised to 1.0; total internal reflection returns 1.0 and
// sets rsp_tuser.
module dielectric_fresnel_reflectance_top #(
   parameter int FRAC_BITS = dfr_pkg::FRAC_BITS_DEF
) (
   input  wire  clock,
   input  wire  reset,
   input  wire  req_tvalid,
   output logic req_tready,
   // cos_incident [FRAC_BITS:0], index_incident next 15 bits, index_exitant next 15 bits
   input  wire  [((FRAC_BITS + 1 + 2 * dfr_pkg::INDEX_W + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  wire  rsp_tready,
   // reflectance [FRAC_BITS:0], zero padded
   output logic [((FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,
   // total_internal
   output logic rsp_tuser
);
   import dfr_pkg::*;
   `include "dielectric_fresnel_reflectance_top_macros.svh"

   localparam int COS_W  = FRAC_BITS + 1;
   localparam int RSP_W  = ((COS_W + 7) / 8) * 8;
   localparam int NSTG   = 100;
   localparam logic [COS_W-1:0] ONE = COS_W'(1) << FRAC_BITS;
   localparam logic [WB:0]      WONE = (WB + 1)'(1) << WB;

   // whole pipe advances together unless the output is held
   logic en;
   logic [NSTG-1:0] vld_ff;
   logic            rsp_tvalid_ff;

   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[NSTG-1];
      end
   end

   // ---------------- stage 0: clamp inputs, cos^2, index squares
   logic [COS_W-1:0]   cos_raw_in, cos_cl_in;
   logic [INDEX_W-1:0] n1_raw_in, n2_raw_in, n1_in, n2_in;
   logic [WB:0]        c_in;
   logic [WB:0]        c0_ff;
   logic [INDEX_W-1:0] n1_0_ff, n2_0_ff;
   logic [2*WB+1:0]    csq0_ff;
   logic [2*INDEX_W-1:0] n1sq0_ff, n2sq0_ff;

   assign cos_raw_in = req_tdata[COS_W-1:0];
   assign n1_raw_in  = req_tdata[COS_W +: INDEX_W];
   assign n2_raw_in  = req_tdata[COS_W + INDEX_W +: INDEX_W];
   assign cos_cl_in  = (cos_raw_in > ONE) ? ONE : cos_raw_in;
   assign n1_in      = (n1_raw_in < INDEX_ONE) ? INDEX_ONE : n1_raw_in;
   assign n2_in      = (n2_raw_in < INDEX_ONE) ? INDEX_ONE : n2_raw_in;
   // widen the cosine to the internal Q.30 grid
   assign c_in       = (WB + 1)'(cos_cl_in) << (WB - FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff    <= c_in;
         n1_0_ff  <= n1_in;
         n2_0_ff  <= n2_in;
         csq0_ff  <= {{(WB + 1){1'b0}}, c_in} * {{(WB + 1){1'b0}}, c_in};
         n1sq0_ff <= {{INDEX_W{1'b0}}, n1_in} * {{INDEX_W{1'b0}}, n1_in};
         n2sq0_ff <= {{INDEX_W{1'b0}}, n2_in} * {{INDEX_W{1'b0}}, n2_in};
      end
   end

   // ---------------- stage 1: sin^2 = 1 - cos^2
   logic [WB:0]          s2_1_ff;
   logic [2*INDEX_W-1:0] n1sq1_ff, n2sq1_ff;
   logic [WB:0]          c1_ff;
   logic [INDEX_W-1:0]   n1_1_ff, n2_1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_1_ff  <= WONE - (WB + 1)'(csq0_ff >> WB);
         n1sq1_ff <= n1sq0_ff;
         n2sq1_ff <= n2sq0_ff;
         c1_ff    <= c0_ff;
         n1_1_ff  <= n1_0_ff;
         n2_1_ff  <= n2_0_ff;
      end
   end

   // ---------------- stage 2: sin^2 * n1^2
   logic [2*WB:0]        prod2_ff;
   logic [2*INDEX_W-1:0] n2sq2_ff;
   logic [WB:0]          c2_ff;
   logic [INDEX_W-1:0]   n1_2_ff, n2_2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod2_ff <= {{WB{1'b0}}, s2_1_ff} * {{(WB + 1){1'b0}}, n1sq1_ff};
         n2sq2_ff <= n2sq1_ff;
         c2_ff    <= c1_ff;
         n1_2_ff  <= n1_1_ff;
         n2_2_ff  <= n2_1_ff;
      end
   end

   // ---------------- divide stages: floor(sin^2 n1^2 / n2^2), restoring, one bit each
   logic [WB-1:0]        dv_rem_ff [0:WB];
   logic [WB-1:0]        dv_lo_ff  [0:WB];
   logic [WB-1:0]        dv_q_ff   [0:WB];
   logic [2*INDEX_W-1:0] dv_den_ff [0:WB];
   carry_type            dv_cy_ff  [0:WB];
   carry_type            cy2_in;

   always_comb begin
      cy2_in.n1  = n1_2_ff;
      cy2_in.n2  = n2_2_ff;
      cy2_in.c   = c2_ff;
      // total internal reflection when sin^2 n1^2 >= n2^2 in Q.30
      cy2_in.tir = prod2_ff >= {1'b0, n2sq2_ff, {WB{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0] <= WB'(prod2_ff >> WB);
         dv_lo_ff[0]  <= prod2_ff[WB-1:0];
         dv_q_ff[0]   <= '0;
         dv_den_ff[0] <= n2sq2_ff;
         dv_cy_ff[0]  <= cy2_in;
      end
   end

   for (genvar k = 0; k < WB; k++) begin : g_div
      logic [WB:0] rt_in;
      logic        ge_in;
      assign rt_in = {dv_rem_ff[k], dv_lo_ff[k][WB-1]};
      assign ge_in = rt_in >= {1'b0, dv_den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[k+1] <= ge_in ? WB'(rt_in - {1'b0, dv_den_ff[k]}) : rt_in[WB-1:0];
            dv_lo_ff[k+1]  <= dv_lo_ff[k] << 1;
            dv_q_ff[k+1]   <= {dv_q_ff[k][WB-2:0], ge_in};
            dv_den_ff[k+1] <= dv_den_ff[k];
            dv_cy_ff[k+1]  <= dv_cy_ff[k];
         end
      end
   end

   // ---------------- root stages: t = floor(sqrt(cos_t^2 << 30)), two radicand bits each
   localparam int SQ_STEPS = WB + 1;
   logic [WB+1:0]   sq_rem_ff  [0:SQ_STEPS];
   logic [WB:0]     sq_root_ff [0:SQ_STEPS];
   logic [2*WB+1:0] sq_v_ff    [0:SQ_STEPS];
   carry_type       sq_cy_ff   [0:SQ_STEPS];
   logic [WB:0]     ct2_in;

   assign ct2_in = WONE - {1'b0, dv_q_ff[WB]};

   always_ff @(posedge clock) begin
      if (en) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_v_ff[0]    <= {1'b0, ct2_in, {WB{1'b0}}};
         sq_cy_ff[0]   <= dv_cy_ff[WB];
      end
   end

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      logic [WB+3:0] rt_in, trial_in;
      logic          ge_in;
      assign rt_in    = {sq_rem_ff[j], sq_v_ff[j][2*WB+1:2*WB]};
      assign trial_in = {1'b0, sq_root_ff[j], 2'b01};
      assign ge_in    = rt_in >= trial_in;
      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[j+1]  <= ge_in ? (WB + 2)'(rt_in - trial_in) : rt_in[WB+1:0];
            sq_root_ff[j+1] <= {sq_root_ff[j][WB-1:0], ge_in};
            sq_v_ff[j+1]    <= sq_v_ff[j] << 2;
            sq_cy_ff[j+1]   <= sq_cy_ff[j];
         end
      end
   end

   // ---------------- multiply stage: n1 c, n2 t, n1 t, n2 c
   localparam int PW = INDEX_W + WB + 1;
   logic [PW-1:0] ma_ff, mb_ff, mp_ff, mq_ff;
   logic          tir_m_ff;
   carry_type     cyt_in;
   logic [WB:0]   t_in;

   assign cyt_in = sq_cy_ff[SQ_STEPS];
   assign t_in   = sq_root_ff[SQ_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff    <= PW'(cyt_in.n1) * PW'(cyt_in.c);
         mb_ff    <= PW'(cyt_in.n2) * PW'(t_in);
         mp_ff    <= PW'(cyt_in.n1) * PW'(t_in);
         mq_ff    <= PW'(cyt_in.n2) * PW'(cyt_in.c);
         tir_m_ff <= cyt_in.tir;
      end
   end

   // ---------------- difference and sum stage
   logic [PW-1:0] ds_ff, dp_ff;
   logic [PW:0]   ss_ff, sp_ff;
   logic          tir_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ds_ff    <= (ma_ff >= mb_ff) ? (ma_ff - mb_ff) : (mb_ff - ma_ff);
         dp_ff    <= (mp_ff >= mq_ff) ? (mp_ff - mq_ff) : (mq_ff - mp_ff);
         ss_ff    <= {1'b0, ma_ff} + {1'b0, mb_ff};
         sp_ff    <= {1'b0, mp_ff} + {1'b0, mq_ff};
         tir_d_ff <= tir_m_ff;
      end
   end

   // ---------------- ratio divides, s and p side by side
   logic [PW:0]   fs_r_ff [0:WB];
   logic [PW:0]   fp_r_ff [0:WB];
   logic [PW:0]   fs_d_ff [0:WB];
   logic [PW:0]   fp_d_ff [0:WB];
   logic [WB-1:0] fs_q_ff [0:WB];
   logic [WB-1:0] fp_q_ff [0:WB];
   logic          fs_sat_ff [0:WB];
   logic          fp_sat_ff [0:WB];
   logic          f_tir_ff  [0:WB];

   always_ff @(posedge clock) begin
      if (en) begin
         fs_r_ff[0]   <= {1'b0, ds_ff};
         fp_r_ff[0]   <= {1'b0, dp_ff};
         fs_d_ff[0]   <= ss_ff;
         fp_d_ff[0]   <= sp_ff;
         fs_q_ff[0]   <= '0;
         fp_q_ff[0]   <= '0;
         // ratio of one or more is clipped to one
         fs_sat_ff[0] <= {1'b0, ds_ff} >= ss_ff;
         fp_sat_ff[0] <= {1'b0, dp_ff} >= sp_ff;
         f_tir_ff[0]  <= tir_d_ff;
      end
   end

   for (genvar k = 0; k < WB; k++) begin : g_fdiv
      logic [PW+1:0] rs_in, rp_in;
      logic          gs_in, gp_in;
      assign rs_in = {fs_r_ff[k], 1'b0};
      assign rp_in = {fp_r_ff[k], 1'b0};
      assign gs_in = rs_in >= {1'b0, fs_d_ff[k]};
      assign gp_in = rp_in >= {1'b0, fp_d_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            fs_r_ff[k+1]   <= gs_in ? (PW + 1)'(rs_in - {1'b0, fs_d_ff[k]}) : rs_in[PW:0];
            fp_r_ff[k+1]   <= gp_in ? (PW + 1)'(rp_in - {1'b0, fp_d_ff[k]}) : rp_in[PW:0];
            fs_q_ff[k+1]   <= {fs_q_ff[k][WB-2:0], gs_in};
            fp_q_ff[k+1]   <= {fp_q_ff[k][WB-2:0], gp_in};
            fs_d_ff[k+1]   <= fs_d_ff[k];
            fp_d_ff[k+1]   <= fp_d_ff[k];
            fs_sat_ff[k+1] <= fs_sat_ff[k];
            fp_sat_ff[k+1] <= fp_sat_ff[k];
            f_tir_ff[k+1]  <= f_tir_ff[k];
         end
      end
   end

   // ---------------- square stage: ratio^2 back to Q.30
   logic [WB:0]     ratio_s_in, ratio_p_in;
   logic [2*WB+1:0] sqs_in, sqp_in;
   logic [WB:0]     rs_ff, rp_ff;
   logic            tir_q_ff;

   assign ratio_s_in = fs_sat_ff[WB] ? WONE : {1'b0, fs_q_ff[WB]};
   assign ratio_p_in = fp_sat_ff[WB] ? WONE : {1'b0, fp_q_ff[WB]};
   assign sqs_in = {{(WB + 1){1'b0}}, ratio_s_in} * {{(WB + 1){1'b0}}, ratio_s_in};
   assign sqp_in = {{(WB + 1){1'b0}}, ratio_p_in} * {{(WB + 1){1'b0}}, ratio_p_in};

   always_ff @(posedge clock) begin
      if (en) begin
         rs_ff    <= (WB + 1)'(sqs_in >> WB);
         rp_ff    <= (WB + 1)'(sqp_in >> WB);
         tir_q_ff <= f_tir_ff[WB];
      end
   end

   // ---------------- output register: mean, round half up, saturate
   logic [WB+2:0]    sum_in, res_full_in;
   logic [COS_W-1:0] res_in;
   logic [COS_W-1:0] refl_ff;
   logic             tir_o_ff;

   assign sum_in      = (WB + 3)'(rs_ff) + (WB + 3)'(rp_ff) + ((WB + 3)'(1) << (WB - FRAC_BITS));
   assign res_full_in = sum_in >> (WB + 1 - FRAC_BITS);
   assign res_in      = (res_full_in > (WB + 3)'(ONE)) ? ONE : res_full_in[COS_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff  <= tir_q_ff ? ONE : res_in;
         tir_o_ff <= tir_q_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(refl_ff);
   assign rsp_tuser  = tir_o_ff;

   // ---------------- checks
   `DFR_ASSERT(a_tir_full, clock, reset, rsp_tvalid_ff && tir_o_ff |-> refl_ff == ONE, "tir result not one")
   `DFR_ASSERT(a_sat, clock, reset, rsp_tvalid_ff |-> refl_ff <= ONE, "reflectance above one")
   `DFR_ASSERT(a_freeze, clock, reset, !en |=> $stable(vld_ff), "pipe moved while stalled")
   `DFR_ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_tvalid_ff && vld_ff == '0, "valid after reset")
endmodule
`default_nettype wire

// ===== tb/dielectric_fresnel_reflectance_top_tb.sv =====
`timescale 1ns / 1ps

// expected reflectance results, oldest first
class reflectance_board;
   typedef struct {
      logic [15:0] refl;
      logic        tir;
   } fresnel_result_type;

   fresnel_result_type pending[$];
   int unsigned        errors;

   static function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // floor(num * 2^30 / den), capped at one
   static function longint unsigned ratio30(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      if (num >= den) return 64'd1 << 30;
      for (int i = 0; i < 30; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return q;
   endfunction

   static function longint unsigned absdiff(longint unsigned a, longint unsigned b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function void note_request(logic [15:0] cosv, logic [14:0] n1i, logic [14:0] n2i);
      fresnel_result_type res;
      longint unsigned wone, cs, n1, n2, c, s2, n1sq, n2sq, ct2, t;
      longint unsigned a, b, p, q, rsr, rpr, sum, val;
      wone = 64'd1 << 30;
      cs = (cosv > 16'd32768) ? 64'd32768 : cosv;
      n1 = (n1i < 15'd8192) ? 64'd8192 : n1i;
      n2 = (n2i < 15'd8192) ? 64'd8192 : n2i;
      c = cs << 15;
      s2 = wone - ((c * c) >> 30);
      n1sq = n1 * n1;
      n2sq = n2 * n2;
      if (s2 * n1sq >= (n2sq << 30)) begin
         res.refl = 16'd32768;
         res.tir = 1'b1;
      end else begin
         ct2 = wone - (s2 * n1sq) / n2sq;
         t = isqrt(ct2 << 30);
         a = n1 * c;
         b = n2 * t;
         p = n1 * t;
         q = n2 * c;
         rsr = ratio30(absdiff(a, b), a + b);
         rpr = ratio30(absdiff(p, q), p + q);
         sum = ((rsr * rsr) >> 30) + ((rpr * rpr) >> 30);
         val = (sum + (64'd1 << 15)) >> 16;
         if (val > 32768) val = 32768;
         res.refl = val[15:0];
         res.tir = 1'b0;
      end
      pending = {pending, res};
   endfunction

   function void check_result(logic [15:0] refl, logic tir);
      fresnel_result_type exp_res;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected transfer refl=%0d tir=%0b", refl, tir);
         return;
      end
      exp_res = pending.pop_front();
      if (refl !== exp_res.refl || tir !== exp_res.tir) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
               exp_res.refl, exp_res.tir, refl, tir);
      end
   endfunction
endclass

module dielectric_fresnel_reflectance_top_tb;
   localparam int LATENCY = 101;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   wire         req_tready;
   // cos_incident [15:0], index_incident [30:16], index_exitant [45:31], zero pad
   logic [47:0] req_tdata;
   wire         rsp_tvalid;
   logic        rsp_tready;
   // reflectance [15:0]
   wire  [15:0] rsp_tdata;
   // total_internal
   wire         rsp_tuser;

   reflectance_board board;
   int unsigned      cycles;
   bit               hold_off;   // long receiver stall requested by stimulus

   dielectric_fresnel_reflectance_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // send one transfer after the given gap; valid stays high if no gap follows
   task automatic send_item(logic [15:0] cosv, logic [14:0] n1, logic [14:0] n2,
                            int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, n2, n1, cosv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cosv, n1, n2);
   endtask

   task automatic send_rand(int gap);
      logic [15:0] cosv;
      logic [14:0] n1, n2;
      int kind;
      kind = $urandom_range(0, 9);
      cosv = (kind == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
      n1 = (kind == 1) ? 15'($urandom) : 15'($urandom_range(8192, 32767));
      n2 = (kind == 2) ? 15'($urandom) : 15'($urandom_range(8192, 32767));
      // for four kinds in ten, a smaller n2 so both tir and normal paths are common
      if (kind >= 6) n2 = 15'($urandom_range(8192, 16384));
      send_item(cosv, n1, n2, gap);
   endtask

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      int gap;
      board = new();
      hold_off = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_item(16'd32768, 15'd8192, 15'd8192, 0);   // normal incidence, equal indices
      send_item(16'd0, 15'd8192, 15'd8192, 0);       // grazing, equal indices (tir)
      send_item(16'd0, 15'd12288, 15'd8192, 0);      // grazing into thinner medium
      send_item(16'hFFFF, 15'd12288, 15'd8192, 0);   // cosine above one
      send_item(16'd40000, 15'd0, 15'd100, 0);       // indices below one
      send_item(16'd32768, 15'd32767, 15'd8192, 0);  // extreme contrast
      send_item(16'd32768, 15'd8192, 15'd32767, 0);
      send_item(16'd1, 15'd32767, 15'd32767, 1);
      send_item(16'd16384, 15'd32767, 15'd8192, 0);  // tir
      send_item(16'd16384, 15'd12288, 15'd8192, 2);
      send_item(16'd32767, 15'd12000, 15'd12001, 0);
      send_item(16'd1000, 15'h7FFF, 15'h7FFF, 0);
      send_item(16'h5555, 15'h2AAA, 15'h5555, 0);
      send_item(16'h2AAA, 15'h5555, 15'h2AAA, 0);

      // sender pause until everything has drained
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);

      for (int i = 0; i < 1950; i++) begin
         if (i == 400) hold_off = 1'b1;
         if (i == 1000) begin
            req_tvalid <= 1'b0;
            while (board.pending.size() != 0) @(posedge clock);
         end
         if (i >= 1500 && i < 1700) gap = 0;
         else gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0;
         send_rand(gap);
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
